### rtl/drc_pkg.sv
// Shared types and constants for the duplex ring channel.
// No dependencies; imported by every module of the block.
package drc_pkg;

  localparam int unsigned RING_DEPTH_DEF = 16;
  localparam int unsigned WORD_W         = 32;
  localparam int unsigned CFG_W          = 5;
  localparam int unsigned CAP_RESET_VAL  = 16;

  typedef enum logic [2:0] {
    FN_SEND   = 3'd0,
    FN_RECV   = 3'd1,
    FN_POLL   = 3'd2,
    FN_CLOSE  = 3'd3,
    FN_DROP   = 3'd4,
    FN_REOPEN = 3'd5
  } drc_func_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_CLOSED  = 3'd3,
    ST_DROPPED = 3'd4
  } drc_status_t;

  typedef enum logic [1:0] {
    LS_OPEN    = 2'd0,
    LS_CLOSED  = 2'd1,
    LS_DROPPED = 2'd2
  } drc_link_t;

  typedef struct packed {
    logic [2:0]               func;
    logic                     endpoint;
    logic signed [WORD_W-1:0] send_word;
  } drc_cmd_t;

  typedef struct packed {
    logic [2:0]               status;
    logic signed [WORD_W-1:0] recv_word;
    logic [1:0]               chan_state;
  } drc_rsp_t;

  // per-ring controls from the decode stage
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } drc_ring_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } drc_ring_sts_t;

endpackage

### rtl/drc_ring.sv
// One direction of the channel: word store, wrapping pointers, fill count.
// Depends on drc_pkg.
module drc_ring import drc_pkg::*; #(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  drc_ring_ctl_t                       ctl,
  input  logic [$clog2(RING_DEPTH+1)-1:0]     cap,
  input  logic [WORD_W-1:0]                   wdata,
  output drc_ring_sts_t                       sts,
  output logic [WORD_W-1:0]                   rdata
);

  localparam int unsigned CAP_W = $clog2(RING_DEPTH + 1);
  localparam int unsigned PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  logic [WORD_W-1:0] mem [RING_DEPTH];
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W-1:0]  wr_ptr;
  logic [CAP_W-1:0]  count;

  // advance with wrap at the latched capacity
  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p,
                                            input logic [CAP_W-1:0] c);
    logic [CAP_W-1:0] n;
    n = CAP_W'(p) + CAP_W'(1);
    return (n >= c) ? '0 : PTR_W'(n);
  endfunction

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_ptr] <= wdata;
    end
    rdata <= mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else if (ctl.push) begin
      wr_ptr <= bump(wr_ptr, cap);
      count  <= count + CAP_W'(1);
    end else if (ctl.pop) begin
      rd_ptr <= bump(rd_ptr, cap);
      count  <= count - CAP_W'(1);
    end
  end

  assign sts.full  = (count >= cap);
  assign sts.empty = (count == '0);

endmodule

### rtl/duplex_ring_channel_unit.sv
// Top level of the duplex ring channel: request register, decode, link state,
// result register. Depends on drc_pkg and drc_ring.
//
//  channel   | handshake              | payload    | direction
//  ----------+------------------------+------------+----------
//  request   | start & !busy          | cmd        | in
//  result    | done (one cycle)       | rsp        | out
//  config    | cfg_we                 | cfg_wdata  | in
//
// A request is taken every cycle while busy is low; its result shows for one
// cycle on done. The result passes through the request register and the result
// register (ring read data lands with the result). busy is high only in reset.
// Reset is synchronous: link open, rings empty, capacity min(16, RING_DEPTH).
// The receiver cannot stall; no backpressure exists anywhere.
module duplex_ring_channel_unit import drc_pkg::*; #(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  drc_cmd_t         cmd,
  output logic             busy,
  output logic             done,
  output drc_rsp_t         rsp,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int unsigned CAP_W = $clog2(RING_DEPTH + 1);
  localparam int unsigned CMP_W = (CAP_W > CFG_W) ? CAP_W : CFG_W;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(RING_DEPTH);
  localparam logic [CAP_W-1:0] CAP_RST =
    CAP_W'((RING_DEPTH < CAP_RESET_VAL) ? RING_DEPTH : CAP_RESET_VAL);

  // config register and latched capacity
  logic [CFG_W-1:0] ring_capacity;
  logic [CAP_W-1:0] eff_cap;
  logic [CAP_W-1:0] cap_clamped;
  logic [CMP_W-1:0] cfg_ext;

  // request stage
  logic     req_valid;
  drc_cmd_t req;

  // state and decode
  drc_link_t     link_state;
  drc_link_t     link_next;
  drc_status_t   status_next;
  logic          took_next;
  drc_ring_ctl_t fwd_ctl;
  drc_ring_ctl_t rev_ctl;
  drc_ring_sts_t fwd_sts;
  drc_ring_sts_t rev_sts;
  drc_ring_sts_t peer_sts;
  drc_status_t   empty_status;
  logic [WORD_W-1:0] fwd_rdata;
  logic [WORD_W-1:0] rev_rdata;

  // result stage
  drc_status_t status;
  drc_link_t   chan_state;
  logic        took;
  logic        took_ep;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_capacity <= CFG_W'(CAP_RESET_VAL);
    end else if (cfg_we) begin
      ring_capacity <= cfg_wdata;
    end
  end

  // 0 reads as 1, anything above the depth as the depth
  assign cfg_ext = CMP_W'(ring_capacity);
  always_comb begin
    if (cfg_ext == '0) begin
      cap_clamped = CAP_W'(1);
    end else if (cfg_ext > DEPTH_C) begin
      cap_clamped = CAP_W'(RING_DEPTH);
    end else begin
      cap_clamped = CAP_W'(cfg_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start && !busy;
    end
    req <= cmd;
  end

  // receive and poll look at the ring the peer fills
  assign peer_sts = req.endpoint ? fwd_sts : rev_sts;

  always_comb begin
    case (link_state)
      LS_CLOSED:  empty_status = ST_CLOSED;
      LS_DROPPED: empty_status = ST_DROPPED;
      default:    empty_status = ST_EMPTY;
    endcase
  end

  always_comb begin
    fwd_ctl     = '0;
    rev_ctl     = '0;
    status_next = ST_OK;
    took_next   = 1'b0;
    link_next   = link_state;
    if (req_valid) begin
      case (req.func)
        FN_SEND: begin
          if (link_state == LS_CLOSED) begin
            status_next = ST_CLOSED;
          end else if (link_state == LS_DROPPED) begin
            status_next = ST_DROPPED;
          end else if (req.endpoint) begin
            if (rev_sts.full) status_next = ST_FULL;
            else              rev_ctl.push = 1'b1;
          end else begin
            if (fwd_sts.full) status_next = ST_FULL;
            else              fwd_ctl.push = 1'b1;
          end
        end
        FN_RECV, FN_POLL: begin
          if (peer_sts.empty) begin
            status_next = empty_status;
          end else if (req.func == FN_RECV) begin
            took_next = 1'b1;
            if (req.endpoint) fwd_ctl.pop = 1'b1;
            else              rev_ctl.pop = 1'b1;
          end
        end
        FN_CLOSE: begin
          if (link_state == LS_OPEN) link_next = LS_CLOSED;
        end
        FN_DROP: begin
          link_next = LS_DROPPED;
        end
        FN_REOPEN: begin
          fwd_ctl.clear = 1'b1;
          rev_ctl.clear = 1'b1;
          link_next     = LS_OPEN;
        end
        default: begin
          // unused codes: no operation, status ok
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_state <= LS_OPEN;
      eff_cap    <= CAP_RST;
      done       <= 1'b0;
      took       <= 1'b0;
    end else begin
      link_state <= link_next;
      if (req_valid && req.func == FN_REOPEN) begin
        eff_cap <= cap_clamped;
      end
      done <= req_valid;
      took <= took_next;
    end
    status     <= status_next;
    chan_state <= link_next;
    took_ep    <= req.endpoint;
  end

  drc_ring #(.RING_DEPTH(RING_DEPTH)) u_fwd (
    .clk   (clk),
    .rst   (rst),
    .ctl   (fwd_ctl),
    .cap   (eff_cap),
    .wdata (req.send_word),
    .sts   (fwd_sts),
    .rdata (fwd_rdata)
  );

  drc_ring #(.RING_DEPTH(RING_DEPTH)) u_rev (
    .clk   (clk),
    .rst   (rst),
    .ctl   (rev_ctl),
    .cap   (eff_cap),
    .wdata (req.send_word),
    .sts   (rev_sts),
    .rdata (rev_rdata)
  );

  // ring read data is registered alongside the result
  assign rsp.status     = status;
  assign rsp.chan_state = chan_state;
  assign rsp.recv_word  = took ? (took_ep ? fwd_rdata : rev_rdata) : '0;

endmodule

### rtl/drc_chk.sv
// Port-level checks for duplex_ring_channel_unit, attached by bind.
// Depends on drc_pkg.
module drc_chk import drc_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input logic     done,
  input drc_rsp_t rsp
);

  a_req_gets_rsp: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("request without result");

  a_rsp_has_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without request");

  a_word_only_ok: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.recv_word != '0) |-> (rsp.status == ST_OK))
    else $error("word returned with failing status");

  a_full_when_open: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == ST_FULL) |-> (rsp.chan_state == LS_OPEN))
    else $error("full reported on a link that is not open");

  a_dropped_state: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == ST_DROPPED) |-> (rsp.chan_state == LS_DROPPED))
    else $error("dropped status with other link state");

endmodule

bind duplex_ring_channel_unit drc_chk u_drc_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);
